### rtl/jpm_pkg.sv
package jpm_pkg;

  localparam int MAX_JOINTS = 6;
  localparam int POS_W      = 24;
  localparam int JC_W       = 3;
  localparam logic [JC_W-1:0] JC_RESET = JC_W'(MAX_JOINTS);

  localparam int JIDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  // second difference needs two extra bits; its square fits one bit short of double
  localparam int DIFF_W = POS_W + 2;
  localparam int PROD_W = 2 * DIFF_W - 1;
  localparam int SUM_W  = PROD_W + JIDX_W;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;

  localparam int LEN_W    = 40;
  localparam int SMOOTH_W = 63;
  localparam int SEC_W    = 31;
  localparam int NSEC_W   = 30;

  localparam logic [LEN_W-1:0]    LEN_MAX    = '1;
  localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = '1;

  typedef logic [MAX_JOINTS-1:0][POS_W-1:0] pos_vec_t;

  typedef struct packed {
    logic signed [POS_W-1:0] joint_pos_0;
    logic signed [POS_W-1:0] joint_pos_1;
    logic signed [POS_W-1:0] joint_pos_2;
    logic signed [POS_W-1:0] joint_pos_3;
    logic signed [POS_W-1:0] joint_pos_4;
    logic signed [POS_W-1:0] joint_pos_5;
    logic [SEC_W-1:0]        time_sec;
    logic [NSEC_W-1:0]       time_nanosec;
    logic                    last_point;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0]    arc_length;
    logic [SMOOTH_W-1:0] smoothness;
    logic [SEC_W-1:0]    duration_sec;
    logic [NSEC_W-1:0]   duration_nanosec;
    logic                saturated;
  } result_t;

endpackage

### rtl/jpm_isqrt.sv
module jpm_isqrt
  import jpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;

  // restoring digit recurrence, one root bit per cycle
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial  = {1'b0, root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("root unit restarted while busy");

endmodule

### rtl/jpm_sumsq.sv
module jpm_sumsq
  import jpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [JC_W-1:0]  n,
  input  pos_vec_t         cur_pt,
  input  pos_vec_t         prev_pt,
  input  pos_vec_t         pbp_pt,
  output logic             done,
  output logic [SUM_W-1:0] sum1,
  output logic [SUM_W-1:0] sum2
);

  logic              run;
  logic [JIDX_W-1:0] j;
  logic              kind;
  logic              v1, k1, v2, k2;

  logic signed [DIFF_W-1:0]   c_x, p_x, b_x, d1, d2;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [2*DIFF_W-1:0] prod_full;
  logic [PROD_W-1:0]          prod_r;
  logic                       in_use;

  always_comb begin
    c_x = {{2{cur_pt[j][POS_W-1]}}, cur_pt[j]};
    p_x = {{2{prev_pt[j][POS_W-1]}}, prev_pt[j]};
    b_x = {{2{pbp_pt[j][POS_W-1]}}, pbp_pt[j]};
    d1  = c_x - p_x;
    d2  = c_x - (p_x <<< 1) + b_x;
    in_use    = (JC_W'(j) < n);
    prod_full = diff_r * diff_r;
  end

  // issue: first and second difference of each joint in turn, then two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      j    <= '0;
      kind <= 1'b0;
      v1   <= 1'b0;
      k1   <= 1'b0;
      v2   <= 1'b0;
      k2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= run;
      k1   <= kind;
      v2   <= v1;
      k2   <= k1;
      done <= v2 && !v1 && !run;
      if (start) begin
        run  <= 1'b1;
        j    <= '0;
        kind <= 1'b0;
      end else if (run) begin
        if (kind) begin
          kind <= 1'b0;
          if (j == JIDX_W'(MAX_JOINTS - 1)) begin
            run <= 1'b0;
          end else begin
            j <= j + JIDX_W'(1);
          end
        end else begin
          kind <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= in_use ? (kind ? d2 : d1) : '0;
    prod_r <= prod_full[PROD_W-1:0];
    if (start) begin
      sum1 <= '0;
      sum2 <= '0;
    end else if (v2) begin
      if (k2) begin
        sum2 <= sum2 + SUM_W'(prod_r);
      end else begin
        sum1 <= sum1 + SUM_W'(prod_r);
      end
    end
  end

  a_start_empty: assert property (@(posedge clk) disable iff (rst)
    start |-> !run && !v1 && !v2)
    else $error("sum-of-squares restarted with work in flight");

endmodule

### rtl/joint_path_metrics_top.sv
// Joint trajectory metrics: path length and smoothness, one waypoint per item.
// Input channel item_valid/item_ready carries one waypoint (six Q4.20 joint
// positions, time stamp, last_point). Output channel result_valid/result_ready
// carries one result per trajectory, on the waypoint marked last_point.
// cfg_wr_en/cfg_wr_data set the number of joints in use; write it while idle.
// Each item passes in order through capture, 12 squaring passes through the one
// shared multiplier plus 2 pipeline stages, hand-over, 27 root steps of the
// integer square root, the accumulator update and the return to idle.
// item_ready is low meanwhile, so no new item is accepted until the last one
// is through.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls and a further last_point item completes, that
// item holds in its update step until the register is taken.
// Reset (synchronous, rst high) clears the accumulators, the point count,
// the saturation flag and the output valid, and sets the joint count to six.
module joint_path_metrics_top
  import jpm_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [JC_W-1:0] cfg_wr_data,
  input  logic            item_valid,
  output logic            item_ready,
  input  item_t           item,
  output logic            result_valid,
  input  logic            result_ready,
  output result_t         result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]          state;
  logic [JC_W-1:0]     jc;
  logic [JC_W-1:0]     n;
  item_t               item_r;
  pos_vec_t            cur_pt, prev_pt, pbp_pt;
  logic [1:0]          points_seen;
  logic [LEN_W-1:0]    len_acc;
  logic [SMOOTH_W-1:0] sm_acc;
  logic                ovf;

  logic                accept;
  logic                sq_done, rt_start, rt_done, upd_go;
  logic [SUM_W-1:0]    sum1, sum2;
  logic [ROOT_W-1:0]   root;

  logic [LEN_W:0]      len_sum;
  logic [SMOOTH_W:0]   sm_sum;
  logic                len_ovf, sm_ovf;
  logic [LEN_W-1:0]    len_new;
  logic [SMOOTH_W-1:0] sm_new;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign rt_start   = (state == ST_SQ) && sq_done;
  assign upd_go     = (state == ST_UPD) &&
                      (!item_r.last_point || !result_valid || result_ready);
  assign n = (jc > JC_W'(MAX_JOINTS)) ? JC_W'(MAX_JOINTS) : jc;

  always_comb begin
    cur_pt[0] = item_r.joint_pos_0;
    cur_pt[1] = item_r.joint_pos_1;
    cur_pt[2] = item_r.joint_pos_2;
    cur_pt[3] = item_r.joint_pos_3;
    cur_pt[4] = item_r.joint_pos_4;
    cur_pt[5] = item_r.joint_pos_5;
  end

  jpm_sumsq u_sumsq (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .n       (n),
    .cur_pt  (cur_pt),
    .prev_pt (prev_pt),
    .pbp_pt  (pbp_pt),
    .done    (sq_done),
    .sum1    (sum1),
    .sum2    (sum2)
  );

  jpm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand (RAD_W'(sum1)),
    .done     (rt_done),
    .root     (root)
  );

  // segment length needs one earlier point, second difference needs two
  always_comb begin
    len_sum = {1'b0, len_acc} + (LEN_W + 1)'(root);
    sm_sum  = {1'b0, sm_acc} + (SMOOTH_W + 1)'(sum2);
    len_ovf = (points_seen != 2'd0) && len_sum[LEN_W];
    sm_ovf  = points_seen[1] && sm_sum[SMOOTH_W];
    if (points_seen == 2'd0) begin
      len_new = len_acc;
    end else begin
      len_new = len_ovf ? LEN_MAX : len_sum[LEN_W-1:0];
    end
    if (!points_seen[1]) begin
      sm_new = sm_acc;
    end else begin
      sm_new = sm_ovf ? SMOOTH_MAX : sm_sum[SMOOTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      jc           <= JC_RESET;
      points_seen  <= 2'd0;
      len_acc      <= '0;
      sm_acc       <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        jc <= cfg_wr_data;
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_SQ;
        end
        ST_SQ: begin
          if (sq_done) state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rt_done) state <= ST_UPD;
        end
        ST_UPD: begin
          if (upd_go) begin
            state <= ST_IDLE;
            if (item_r.last_point) begin
              result_valid <= 1'b1;
              points_seen  <= 2'd0;
              len_acc      <= '0;
              sm_acc       <= '0;
              ovf          <= 1'b0;
            end else begin
              len_acc <= len_new;
              sm_acc  <= sm_new;
              ovf     <= ovf || len_ovf || sm_ovf;
              if (points_seen != 2'd3) points_seen <= points_seen + 2'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
    end
    if (upd_go) begin
      pbp_pt  <= prev_pt;
      prev_pt <= cur_pt;
      if (item_r.last_point) begin
        result.arc_length       <= len_new;
        result.smoothness       <= sm_new;
        result.duration_sec     <= item_r.time_sec;
        result.duration_nanosec <= item_r.time_nanosec;
        result.saturated        <= ovf || len_ovf || sm_ovf;
      end
    end
  end

  // a clamped accumulator stays at its maximum for the rest of the trajectory
  a_sat_at_max: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      (result.arc_length == LEN_MAX) || (result.smoothness == SMOOTH_MAX))
    else $error("saturated result without a clamped total");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken while one is in progress");

endmodule
